@@ src/i4dq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i4dq_pkg
// Shared types and constants for the int4 group dequantizer.
// ----------------------------------------------------------------------------
package i4dq_pkg;

  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned DIFF_W   = 9;
  localparam logic [15:0] BF16_QNAN = 16'h7FC0;

  typedef struct packed {
    logic [7:0]        packed_byte;
    logic [31:0]       scale_bits;
    logic signed [7:0] zero_point;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] low_value;
    logic [15:0] high_value;
    logic        last_pair;
  } out_item_t;

  // one lane's stage-1 result: special-case info and raw product
  typedef struct packed {
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic        sign;
    logic [9:0]  exp;      // biased exponent of scale, unbiased-by-one for subnormals
    logic [32:0] mant;     // |d| * significand
  } lane_prod_t;

endpackage
`default_nettype wire

@@ src/int4_group_dequant_bf16.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// int4_group_dequant_bf16
// Top level: two dequant lanes and the merge into one result transaction.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the output is not stalled. An accepted
// transaction is registered in stage 1, then in stage 2, which drives the result:
// each lane has two register stages (product, then round and narrow), and the merge adds none.
// The pipeline advances whenever its output slot is free or being taken, so
// full rate holds under no stall; a result held by the receiver stalls the
// input until it is taken.
module int4_group_dequant_bf16 (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire i4dq_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output i4dq_pkg::out_item_t       out_data
);
  import i4dq_pkg::*;

  logic zp_en_r, v1_r, v2_r, l1_r, l2_r;
  logic adv2, adv1;
  logic [15:0] lo, hi;

  // pipeline control: stage 2 holds the output
  assign adv2     = !v2_r || out_ready;
  assign adv1     = adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zp_en_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
    end else begin
      if (cfg_we) zp_en_r <= cfg_wdata;
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  // row-end flag travels alongside
  always_ff @(posedge clk) begin
    if (adv1) l1_r <= in_data.last_byte;
    if (adv2) l2_r <= l1_r;
  end

  i4dq_lane u_lo (.clk, .en1(adv1), .en2(adv2), .nibble(in_data.packed_byte[3:0]),
    .zero_point(in_data.zero_point), .zp_en(zp_en_r),
    .scale_bits(in_data.scale_bits), .bf16_out(lo));
  i4dq_lane u_hi (.clk, .en1(adv1), .en2(adv2), .nibble(in_data.packed_byte[7:4]),
    .zero_point(in_data.zero_point), .zp_en(zp_en_r),
    .scale_bits(in_data.scale_bits), .bf16_out(hi));

  // merge lanes into the result transaction
  assign out_valid = v2_r;
  assign out_data  = '{low_value: lo, high_value: hi, last_pair: l2_r};
endmodule
`default_nettype wire

@@ src/i4dq_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i4dq_lane
// One dequant lane: difference times scale (stage 1), then normalize and
// round to f32 and narrow to bf16 (stage 2). Two register stages.
// ----------------------------------------------------------------------------
module i4dq_lane (
  input  wire logic                   clk,
  input  wire logic                   en1,
  input  wire logic                   en2,
  input  wire logic [3:0]             nibble,
  input  wire logic signed [7:0]      zero_point,
  input  wire logic                   zp_en,
  input  wire logic [31:0]            scale_bits,
  output logic [15:0]                 bf16_out
);
  import i4dq_pkg::*;

  logic signed [DIFF_W-1:0] d;
  logic [DIFF_W-1:0]        dmag;
  logic [7:0]               se;
  logic [22:0]              sm;
  logic [23:0]              sig;
  lane_prod_t               p_nxt, p_r;
  logic [15:0]              out_nxt, bf_r;

  // difference and magnitude
  always_comb begin
    d    = zp_en ? ($signed({{(DIFF_W-NIBBLE_W){nibble[3]}}, nibble})
                   - $signed({zero_point[7], zero_point}))
                 : $signed({{(DIFF_W-NIBBLE_W){nibble[3]}}, nibble});
    dmag = d[DIFF_W-1] ? DIFF_W'(-d) : d;
    se   = scale_bits[30:23];
    sm   = scale_bits[22:0];
    sig  = {(se != 8'd0), sm};
    p_nxt.sign    = scale_bits[31] ^ d[DIFF_W-1];
    p_nxt.is_nan  = ((se == 8'hFF) && (sm != 23'd0)) ||
                    ((se == 8'hFF) && (dmag == '0));
    p_nxt.is_inf  = (se == 8'hFF);
    p_nxt.is_zero = (dmag == '0) || (sig == 24'd0);
    p_nxt.exp     = (se == 8'd0) ? 10'd1 : {2'b00, se};
    p_nxt.mant    = 33'(dmag) * 33'(sig);
  end

  always_ff @(posedge clk) begin
    if (en1) p_r <= p_nxt;
  end

  // normalize, round to f32, then narrow to bf16
  logic [5:0]  lz;
  logic [32:0] norm;
  logic signed [11:0] e;    // exponent of bit 32 of norm, biased
  logic [32:0] sh;
  logic [4:0]  rsh;
  logic        sticky;
  logic [24:0] rm;
  logic [31:0] f;
  logic [31:0] fb;
  always_comb begin
    lz = 6'd33;
    for (int i = 0; i < 33; i++) if (p_r.mant[i]) lz = 6'(32 - i);
    norm = p_r.mant << lz;
    // value = mant * 2^(exp-127-23); bit32 of norm weight 2^(exp-127-23+32-lz)
    e = $signed({2'b00, p_r.exp}) + 12'sd9 - $signed({6'd0, lz});
    // f32 biased exponent of leading bit = e; subnormal when e < 1
    sh = norm; sticky = 1'b0; rsh = '0;
    if (e < 12'sd1) begin
      rsh = (e < -12'sd24) ? 5'd26 : 5'(12'sd1 - e);
      for (int i = 0; i < 33; i++) if (i < rsh && norm[i]) sticky = 1'b1;
      sh = norm >> rsh;
    end
    sticky = sticky | (sh[7:0] != 8'd0);
    rm = {1'b0, sh[32:9]} + 25'((sh[8] & (sticky | sh[9])) ? 1 : 0);
    f = '0;
    if (e < 12'sd1) begin
      f = {p_r.sign, 8'(rm[23]), rm[22:0]};  // carry into normal handled
    end else if (rm[24]) begin
      f = (e + 12'sd1 >= 12'sd255) ? {p_r.sign, 8'hFF, 23'd0}
                                   : {p_r.sign, 8'(e + 12'sd1), rm[23:1]};
    end else begin
      f = (e >= 12'sd255) ? {p_r.sign, 8'hFF, 23'd0}
                          : {p_r.sign, 8'(e), rm[22:0]};
    end
    if (p_r.is_inf)        f = {p_r.sign, 8'hFF, 23'd0};
    else if (p_r.is_zero)  f = {p_r.sign, 31'd0};
    fb = f + 32'h7FFF + {31'd0, f[16]};
    out_nxt = p_r.is_nan ? BF16_QNAN : fb[31:16];
  end

  always_ff @(posedge clk) begin
    if (en2) bf_r <= out_nxt;
  end
  assign bf16_out = bf_r;
endmodule
`default_nettype wire

@@ src/i4dq_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i4dq_checker
// Port-level checks on the dequantizer handshakes.
// ----------------------------------------------------------------------------
module i4dq_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire i4dq_pkg::out_item_t out_data
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  // no result out of reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("rst");
  // free output slot means ready
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("rdy");
  // accepted item shows as a valid result after stage 1 and stage 2 when the output is not stalled
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready |=> out_valid) else $error("lat");
endmodule

bind int4_group_dequant_bf16 i4dq_checker u_chk (.clk, .rst_n, .in_valid, .in_ready,
  .out_valid, .out_ready, .out_data);
`default_nettype wire
